// ===== src/substring_search_first_last_count_macros.svh =====
// Assertion macros for the substring search RTL.
`ifndef SUBSTRING_SEARCH_FIRST_LAST_COUNT_MACROS_SVH
`define SUBSTRING_SEARCH_FIRST_LAST_COUNT_MACROS_SVH

`ifndef ASSERT_OFF
// Check prop on every clk edge outside reset.
`define SSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check prop on every clk edge, reset included.
`define SSS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SSS_ASSERT(label, prop, msg)
`define SSS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== src/sss_pkg.sv =====
// Types and constants of the streaming substring search.
`timescale 1ns / 1ps
`default_nettype none
package sss_pkg;

  localparam int BYTE_BITS      = 8;
  localparam int LEN_BITS       = 4;
  localparam int MODE_BITS      = 2;
  localparam int OFFSET_BITS    = 32;
  localparam int OUT_POS_BITS   = 32;
  localparam int COUNT_BITS     = 32;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 64;

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] CFG_NEEDLE_BYTES = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_NEEDLE_LEN   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SEARCH_MODE  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_START_OFFSET = 3'd3;

  // Search modes
  localparam logic [MODE_BITS-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_LAST  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_COUNT = 2'd2;

  typedef struct packed {
    logic [BYTE_BITS-1:0] data_byte;
    logic                 last;
  } in_word_t;

  typedef struct packed {
    logic                    found;
    logic [OUT_POS_BITS-1:0] position;
    logic [COUNT_BITS-1:0]   match_count;
  } out_word_t;

endpackage
`default_nettype wire

// ===== src/sss_matcher.sv =====
// Parallel compare of the byte window against the needle for the configured length.
`timescale 1ns / 1ps
`default_nettype none
module sss_matcher #(
  parameter int MAX_NEEDLE = 8
) (
  input  logic [MAX_NEEDLE*sss_pkg::BYTE_BITS-1:0] window,
  input  logic [MAX_NEEDLE*sss_pkg::BYTE_BITS-1:0] needle,
  input  logic [sss_pkg::LEN_BITS-1:0]             needle_len,
  output logic                                     hit
);
  import sss_pkg::*;

  // eq[l][k]: needle byte k sits at window byte l-k for a needle of l+1 bytes
  logic [MAX_NEEDLE-1:0] eq [MAX_NEEDLE];
  logic [MAX_NEEDLE-1:0] len_hit;

  for (genvar l = 0; l < MAX_NEEDLE; l++) begin : g_len
    for (genvar k = 0; k < MAX_NEEDLE; k++) begin : g_byte
      if (k <= l) begin : g_cmp
        assign eq[l][k] = (needle[k*BYTE_BITS +: BYTE_BITS] ==
                           window[(l-k)*BYTE_BITS +: BYTE_BITS]);
      end else begin : g_pad
        assign eq[l][k] = 1'b1;
      end
    end
    assign len_hit[l] = &eq[l];
  end

  // Select the configured length; zero or an oversize length never hits
  always_comb begin
    hit = 1'b0;
    for (int l = 0; l < MAX_NEEDLE; l++) begin
      if (needle_len == LEN_BITS'(l + 1)) begin
        hit = len_hit[l];
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/substring_search_first_last_count.sv =====
// Top level of the streaming substring search: first, last and count modes.
//
// Haystack bytes arrive one word per cycle with a last marker; the block takes
// a new byte every cycle but for the stall named below. Each byte lands in an
// input register, from which one update stage shifts it into a window of
// MAX_NEEDLE bytes, compares all needle lengths in parallel and updates the
// kept match or the count. On a byte marked last the result is loaded into
// the output register as that byte leaves the input register, and the stream
// state clears for the next haystack. The output register lets bytes of the
// next haystack enter while a result waits; only a second last byte stalls
// until the first result is taken. Positions are byte indexes from 0,
// saturating at POSITION_BITS ones. Write configuration only between haystacks.
`timescale 1ns / 1ps
`default_nettype none
`include "substring_search_first_last_count_macros.svh"
module substring_search_first_last_count #(
  parameter int MAX_NEEDLE    = 8,
  parameter int POSITION_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sss_pkg::in_word_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sss_pkg::out_word_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sss_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [sss_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import sss_pkg::*;

  localparam int NEEDLE_BITS = MAX_NEEDLE * BYTE_BITS;
  localparam int CMP_BITS    = (POSITION_BITS > OFFSET_BITS) ? POSITION_BITS : OFFSET_BITS;

  // Configuration registers
  logic [NEEDLE_BITS-1:0] needle;
  logic [LEN_BITS-1:0]    needle_len;
  logic [MODE_BITS-1:0]   search_mode;
  logic [OFFSET_BITS-1:0] start_offset;

  // Input register
  logic     s1_valid;
  in_word_t s1_data;
  logic     s1_advance;

  // Stream state
  logic [NEEDLE_BITS-1:0]   window, window_next;
  logic [POSITION_BITS-1:0] byte_index, byte_index_next;
  logic                     hit_flag, hit_flag_next;
  logic [POSITION_BITS-1:0] hit_position, hit_position_next;
  logic [COUNT_BITS-1:0]    hit_count, hit_count_next;
  logic [POSITION_BITS-1:0] match_start;
  logic                     match_hit;
  logic                     match_ok;
  out_word_t                out_data_next;

  assign cfg_ready = 1'b1;

  // Take configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      needle       <= '0;
      needle_len   <= '0;
      search_mode  <= MODE_FIRST;
      start_offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NEEDLE_BYTES: needle       <= cfg_data[NEEDLE_BITS-1:0];
        CFG_NEEDLE_LEN:   needle_len   <= cfg_data[LEN_BITS-1:0];
        CFG_SEARCH_MODE:  search_mode  <= cfg_data[MODE_BITS-1:0];
        CFG_START_OFFSET: start_offset <= cfg_data[OFFSET_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Advance the held byte unless it is a last byte blocked by a waiting result
  assign s1_advance = s1_valid && (!s1_data.last || !out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  // Shift the new byte into the window and compare
  assign window_next = (window << BYTE_BITS) | NEEDLE_BITS'(s1_data.data_byte);

  sss_matcher #(
    .MAX_NEEDLE (MAX_NEEDLE)
  ) u_matcher (
    .window     (window_next),
    .needle     (needle),
    .needle_len (needle_len),
    .hit        (match_hit)
  );

  // Update kept match, count and result word
  always_comb begin
    byte_index_next   = (byte_index == '1) ? byte_index : byte_index + 1'b1;
    match_start       = byte_index_next - POSITION_BITS'(needle_len);
    match_ok          = match_hit && (byte_index_next >= POSITION_BITS'(needle_len));
    hit_flag_next     = hit_flag;
    hit_position_next = hit_position;
    hit_count_next    = hit_count;
    if (match_ok) begin
      case (search_mode)
        MODE_FIRST: begin
          if (!hit_flag && (CMP_BITS'(match_start) >= CMP_BITS'(start_offset))) begin
            hit_flag_next     = 1'b1;
            hit_position_next = match_start;
          end
        end
        MODE_LAST: begin
          hit_flag_next     = 1'b1;
          hit_position_next = match_start;
        end
        MODE_COUNT: begin
          if (hit_count != '1) begin
            hit_count_next = hit_count + 1'b1;
          end
        end
        default: ;
      endcase
    end

    out_data_next = '0;
    case (search_mode)
      MODE_FIRST, MODE_LAST: begin
        out_data_next.found    = hit_flag_next;
        out_data_next.position = hit_flag_next ? OUT_POS_BITS'(hit_position_next) : '0;
      end
      MODE_COUNT: begin
        out_data_next.match_count = hit_count_next;
      end
      default: ;
    endcase
  end

  // Hold stream state; clear it after each result
  always_ff @(posedge clk) begin
    if (rst) begin
      window       <= '0;
      byte_index   <= '0;
      hit_flag     <= 1'b0;
      hit_position <= '0;
      hit_count    <= '0;
    end else if (s1_advance) begin
      if (s1_data.last) begin
        window       <= '0;
        byte_index   <= '0;
        hit_flag     <= 1'b0;
        hit_position <= '0;
        hit_count    <= '0;
      end else begin
        window       <= window_next;
        byte_index   <= byte_index_next;
        hit_flag     <= hit_flag_next;
        hit_position <= hit_position_next;
        hit_count    <= hit_count_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_data.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_data.last) begin
      out_data <= out_data_next;
    end
  end

  // Checks
  `SSS_ASSERT(a_clear_after_result,
              (s1_advance && s1_data.last) |=> (byte_index == '0 && !hit_flag && hit_count == '0),
              "stream state not cleared after result")
  `SSS_ASSERT(a_index_needs_byte,
              !s1_advance |=> $stable(byte_index),
              "byte index moved without a byte")
  `SSS_ASSERT(a_found_or_count,
              out_valid |-> !(out_data.found && out_data.match_count != '0),
              "found and count both set")
  `SSS_ASSERT(a_position_zero,
              (out_valid && !out_data.found) |-> (out_data.position == '0),
              "position set without a match")

endmodule
`default_nettype wire

// ===== dv/search_result_checker.sv =====
// Checker for the substring search: predicts each result and compares it.
`timescale 1ns / 1ps
module search_result_checker #(
  parameter int MAX_NEEDLE = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  sss_pkg::in_word_t                   in_data,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  sss_pkg::out_word_t                  out_data,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [sss_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [sss_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output int                                  mismatches,
  output int                                  outstanding,
  output int                                  results_checked
);
  import sss_pkg::*;

  // Register copies
  logic [CFG_DATA_BITS-1:0] needle;
  logic [LEN_BITS-1:0]      needle_len;
  logic [MODE_BITS-1:0]     mode;
  logic [OFFSET_BITS-1:0]   min_start;

  // Per-haystack search state
  logic [63:0]             window;
  logic [31:0]             byte_count;
  logic                    kept;
  logic [31:0]             kept_start;
  logic [COUNT_BITS-1:0]   hit_total;

  out_word_t expected_results[$];
  int        bad_count = 0;
  int        checked = 0;

  // True when the newest len bytes of the window spell the needle.
  function automatic logic tail_matches(logic [63:0] win, logic [63:0] pat, int len);
    int k;
    for (k = 0; k < len; k++) begin
      if (pat[8*k +: 8] != win[8*(len-1-k) +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_stream();
    window     = '0;
    byte_count = '0;
    kept       = 1'b0;
    kept_start = '0;
    hit_total  = '0;
  endtask

  // Shift one haystack byte in, update the kept match or count, and queue
  // the result when the byte closes the haystack.
  task automatic absorb_byte(input in_word_t w);
    out_word_t   res;
    logic [31:0] start;
    window = {window[55:0], w.data_byte};
    if (byte_count != 32'hFFFF_FFFF) byte_count = byte_count + 32'd1;
    if (needle_len >= 1 && needle_len <= MAX_NEEDLE && byte_count >= 32'(needle_len) &&
        tail_matches(window, needle, int'(needle_len))) begin
      start = byte_count - 32'(needle_len);
      case (mode)
        MODE_FIRST: begin
          if (!kept && start >= min_start) begin
            kept       = 1'b1;
            kept_start = start;
          end
        end
        MODE_LAST: begin
          kept       = 1'b1;
          kept_start = start;
        end
        MODE_COUNT: begin
          if (hit_total != '1) hit_total = hit_total + 1'b1;
        end
        default: ;
      endcase
    end
    if (w.last) begin
      res = '0;
      if (mode == MODE_FIRST || mode == MODE_LAST) begin
        res.found    = kept;
        res.position = kept ? kept_start : '0;
      end else if (mode == MODE_COUNT) begin
        res.match_count = hit_total;
      end
      expected_results.push_back(res);
      clear_stream();
    end
  endtask

  // Compare one result word against the oldest prediction.
  task automatic check_result(input out_word_t got);
    out_word_t want;
    checked++;
    if (expected_results.size() == 0) begin
      bad_count++;
      $display("%0t: result word with none expected, actual found=%0b position=%0d count=%0d",
               $time, got.found, got.position, got.match_count);
    end else begin
      want = expected_results.pop_front();
      if (got.found !== want.found) begin
        bad_count++;
        $display("%0t: found expected %0b actual %0b", $time, want.found, got.found);
      end
      if (got.position !== want.position) begin
        bad_count++;
        $display("%0t: position expected %0d actual %0d", $time, want.position, got.position);
      end
      if (got.match_count !== want.match_count) begin
        bad_count++;
        $display("%0t: match_count expected %0d actual %0d", $time, want.match_count,
                 got.match_count);
      end
    end
  endtask

  // Watch all three channels on each edge
  always @(posedge clk) begin
    if (rst) begin
      needle     = '0;
      needle_len = '0;
      mode       = MODE_FIRST;
      min_start  = '0;
      clear_stream();
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NEEDLE_BYTES: needle     = cfg_data;
          CFG_NEEDLE_LEN:   needle_len = cfg_data[LEN_BITS-1:0];
          CFG_SEARCH_MODE:  mode       = cfg_data[MODE_BITS-1:0];
          CFG_START_OFFSET: min_start  = cfg_data[OFFSET_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) absorb_byte(in_data);
      if (out_valid && out_ready) check_result(out_data);
    end
    mismatches      <= bad_count;
    outstanding     <= expected_results.size();
    results_checked <= checked;
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the substring search: stimulus, pacing and verdict.
`timescale 1ns / 1ps
module tb_top;
  import sss_pkg::*;

  localparam logic [MODE_BITS-1:0] MODE_UNDEFINED = 2'd3;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  in_word_t                  in_data;
  logic                      out_valid;
  logic                      out_ready;
  out_word_t                 out_data;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  int mismatches;
  int outstanding;
  int results_checked;

  int send_gap_pct = 27;
  int take_stall_pct = 72;
  int haystacks = 0;
  int bytes_sent = 0;

  // Haystack under construction and the needle it is built around
  logic [7:0]  hay_q[$];
  logic [63:0] cur_needle;
  int          cur_len;
  logic [7:0]  alphabet[3];

  substring_search_first_last_count DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  search_result_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= take_stall_pct);
  end

  // Offer one byte after a random gap and hold it until taken
  task automatic push_byte(input logic [7:0] d, input logic l);
    in_word_t w;
    w.data_byte = d;
    w.last      = l;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Write one register; valid stays up for back-to-back writes
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Drop the byte stream and wait until every predicted result is out
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_search(input logic [63:0] nb, input int len,
                                input logic [MODE_BITS-1:0] m, input logic [31:0] off);
    settle();
    write_reg(CFG_NEEDLE_BYTES, nb);
    write_reg(CFG_NEEDLE_LEN, 64'(len));
    write_reg(CFG_SEARCH_MODE, 64'(m));
    write_reg(CFG_START_OFFSET, 64'(off));
    cfg_valid  <= 1'b0;
    cur_needle = nb;
    cur_len    = len;
  endtask

  task automatic send_haystack();
    int i;
    for (i = 0; i < hay_q.size(); i++) push_byte(hay_q[i], i == hay_q.size() - 1);
    haystacks++;
  endtask

  // Pick a small alphabet, a needle drawn mostly from it, a mode and an offset
  task automatic random_search();
    logic [63:0]          nb;
    logic [MODE_BITS-1:0] m;
    logic [31:0]          off;
    int                   len;
    int                   r;
    int                   k;
    for (k = 0; k < 3; k++) alphabet[k] = 8'($urandom);
    r = $urandom_range(0, 19);
    if (r < 16) len = $urandom_range(1, 8);
    else if (r < 17) len = 0;
    else len = $urandom_range(9, 15);
    if ($urandom_range(0, 4) == 0) begin
      nb = {$urandom, $urandom};
    end else begin
      for (k = 0; k < 8; k++) nb[8*k +: 8] = alphabet[$urandom_range(0, 2)];
    end
    case ($urandom_range(0, 9))
      0:       m = MODE_UNDEFINED;
      1, 2, 3: m = MODE_FIRST;
      4, 5, 6: m = MODE_LAST;
      default: m = MODE_COUNT;
    endcase
    r = $urandom_range(0, 9);
    if (r < 6) off = '0;
    else if (r < 9) off = $urandom_range(1, 16);
    else if ($urandom_range(0, 1) == 1) off = 32'hFFFF_FFFF;
    else off = $urandom;
    program_search(nb, len, m, off);
  endtask

  // Mostly short haystacks of alphabet bytes seeded with needle copies
  task automatic random_haystack();
    int n;
    int r;
    int k;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
    hay_q.delete();
    while (hay_q.size() < n) begin
      r = $urandom_range(0, 99);
      if (r < 25 && cur_len >= 1) begin
        for (k = 0; k < cur_len && k < 8; k++) hay_q.push_back(cur_needle[8*k +: 8]);
      end else if (r < 92) begin
        hay_q.push_back(alphabet[$urandom_range(0, 2)]);
      end else begin
        hay_q.push_back(8'($urandom));
      end
    end
    while (hay_q.size() > n) void'(hay_q.pop_back());
  endtask

  initial begin
    int phase;
    int quota;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_NEEDLE_BYTES;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Full-length needle of all ones over a haystack of all ones
    program_search(64'hFFFF_FFFF_FFFF_FFFF, 8, MODE_LAST, 32'd0);
    hay_q.delete();
    repeat (8) hay_q.push_back(8'hFF);
    send_haystack();
    // Earliest match at or past the start offset
    program_search(64'h6261, 2, MODE_FIRST, 32'd2);
    hay_q = '{8'h61, 8'h62, 8'h61, 8'h62};
    send_haystack();
    // Start offset past the end of the haystack
    program_search(64'h6261, 2, MODE_FIRST, 32'hFFFF_FFFF);
    hay_q = '{8'h61, 8'h62};
    send_haystack();
    // Overlapping matches counted
    program_search(64'h6161, 2, MODE_COUNT, 32'd0);
    hay_q = '{8'h61, 8'h61, 8'h61, 8'h61};
    send_haystack();
    // Empty needle
    program_search(64'h0, 0, MODE_FIRST, 32'd0);
    hay_q = '{8'h00};
    send_haystack();
    // Needle length past the window
    program_search(64'h0, 15, MODE_COUNT, 32'd0);
    hay_q = '{8'h00, 8'h00};
    send_haystack();
    // Needle longer than the haystack
    program_search(64'h0, 3, MODE_LAST, 32'd0);
    hay_q = '{8'h00, 8'h00};
    send_haystack();
    // Undefined mode reports all zeros
    program_search(64'h0, 1, MODE_UNDEFINED, 32'd0);
    hay_q = '{8'h00};
    send_haystack();

    // Random haystacks under three pacing regimes
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_gap_pct   = 27;
          take_stall_pct = 72;
        end
        1: begin
          send_gap_pct   = 72;
          take_stall_pct = 27;
        end
        default: begin
          send_gap_pct   = 0;
          take_stall_pct = 0;
        end
      endcase
      quota = bytes_sent + 284;
      random_search();
      while (bytes_sent < quota) begin
        if ($urandom_range(0, 2) == 0) random_search();
        random_haystack();
        send_haystack();
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (20) @(posedge clk);
    $display("Covered %0d haystacks, %0d bytes, %0d result words checked", haystacks,
             bytes_sent, results_checked);
    $display("Modes first, last, count and undefined under three handshake pacings");
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #2000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
